/* design/rkvs_pkg.sv */
// Shared word types and operation codes for the recency-ordered key-value store.
package rkvs_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic MODE_GET  = 1'b0;
  localparam logic MODE_PUSH = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } rkvs_in_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
    logic                      has_recent;
    logic signed [KEY_W-1:0]   latest_key;
    logic [COUNT_W-1:0]        entry_count;
    logic                      overflow;
  } rkvs_out_t;

endpackage

/* design/rkvs_lookup.sv */
// Parallel key compare over the held slots with first-match position and value select.
module rkvs_lookup #(
  parameter int CAPACITY = 16,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic [CAPACITY-1:0][rkvs_pkg::KEY_W-1:0]   slot_keys,
  input  logic [CAPACITY-1:0][rkvs_pkg::VALUE_W-1:0] slot_values,
  input  logic [CW-1:0]                              count,
  input  logic [rkvs_pkg::KEY_W-1:0]                 key,
  output logic                                       found,
  output logic [CW-1:0]                              pos,
  output logic [rkvs_pkg::VALUE_W-1:0]               hit_value
);
  import rkvs_pkg::*;

  logic [CAPACITY-1:0] match;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count) && (slot_keys[i] == key);
    end
  end

  always_comb begin
    pos       = '0;
    hit_value = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = CW'(i);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (slot_values[i] & {VALUE_W{match[i]}});
    end
  end

  assign found = |match;

endmodule

/* design/recency_ordered_key_value_store_core.sv */
// Top level of the recency-ordered key-value store with its slot registers and handshakes.
// The input channel takes one word per operation: a get or a push with a key and a value.
// The result channel returns one word per operation, in order: whether the key was held,
// the value read on a get hit, the most recent key, the entry count and an overflow flag.
// Entries sit in a row of slot registers ordered by recency, slot 0 the most recent.
// An accepted word is held in an input register; once the output register is free, all
// slots are compared in parallel, the hit or new entry moves to slot 0 while the slots
// in front of it move back one place, and the result is captured in an output register.
// One word can be taken every cycle while the receiver does not stall, since each
// operation completes its slot update as its result is captured.
// A push of a new key into a full store changes nothing and reports overflow.
// When the receiver stalls, the result waits in the output register and the input
// register still holds one more word; after that in_ready drops until out_ready returns.
// Reset empties the store at once; slot contents are not cleared, since only slots below
// the entry count are ever compared or read.
module recency_ordered_key_value_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic                rst_n,
  input  logic                clk,
  input  logic                in_valid,
  output logic                in_ready,
  input  rkvs_pkg::rkvs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rkvs_pkg::rkvs_out_t out_data
);
  import rkvs_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0][KEY_W-1:0]   keys_r, keys_nxt;
  logic [CAPACITY-1:0][VALUE_W-1:0] vals_r, vals_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             s_vld_r;
  rkvs_in_t                         s_item_r;
  logic                             o_vld_r;
  rkvs_out_t                        o_data_r, o_data_nxt;

  logic                found;
  logic [CW-1:0]       hit_pos;
  logic [VALUE_W-1:0]  hit_value;
  logic                advance;
  logic                full;
  logic                insert;
  logic                do_move;
  logic [CW-1:0]       move_pos;
  logic [31:0]         cnt_wide;

  rkvs_lookup #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_lookup (
    .slot_keys   (keys_r),
    .slot_values (vals_r),
    .count       (cnt_r),
    .key         (s_item_r.key),
    .found       (found),
    .pos         (hit_pos),
    .hit_value   (hit_value)
  );

  assign advance  = s_vld_r && (!o_vld_r || out_ready);
  assign in_ready = !s_vld_r || advance;

  assign full     = (cnt_r == CW'(CAPACITY));
  assign insert   = (s_item_r.mode == MODE_PUSH) && !found && !full;
  assign do_move  = found || insert;
  assign move_pos = found ? hit_pos : cnt_r;
  assign cnt_nxt  = cnt_r + CW'(insert);
  assign cnt_wide = 32'(cnt_nxt);

  always_comb begin
    keys_nxt = keys_r;
    vals_nxt = vals_r;
    if (do_move) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (CW'(i) <= move_pos) begin
          keys_nxt[i] = keys_r[i-1];
          vals_nxt[i] = vals_r[i-1];
        end
      end
      keys_nxt[0] = s_item_r.key;
      vals_nxt[0] = (s_item_r.mode == MODE_PUSH) ? s_item_r.value : hit_value;
    end
  end

  always_comb begin
    o_data_nxt.found       = found;
    o_data_nxt.read_value  = (s_item_r.mode == MODE_GET && found) ? hit_value : '0;
    o_data_nxt.has_recent  = (cnt_nxt != '0);
    o_data_nxt.latest_key  = (cnt_nxt != '0) ? keys_nxt[0] : '0;
    o_data_nxt.entry_count = cnt_wide[COUNT_W-1:0];
    o_data_nxt.overflow    = (s_item_r.mode == MODE_PUSH) && !found && full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (in_ready) begin
        s_vld_r <= in_valid;
      end
      if (advance) begin
        o_vld_r <= 1'b1;
        cnt_r   <= cnt_nxt;
      end else if (out_ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item_r <= in_data;
    end
    if (advance) begin
      keys_r   <= keys_nxt;
      vals_r   <= vals_nxt;
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An insertion grows the store by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    advance && insert |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insertion did not grow the store by one");

  // An overflow result never reports a hit and leaves the store full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_data_r.overflow |-> !o_data_r.found && cnt_r == CW'(CAPACITY))
    else $error("overflow reported with a hit or a store that is not full");

  // A get never changes the entry count.
  a_get_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s_item_r.mode == MODE_GET |=> cnt_r == $past(cnt_r))
    else $error("get changed the entry count");

endmodule
